// ===== hw/rtl/txdr_pkg.sv =====
package txdr_pkg;

   localparam int RING_DEPTH   = 64;
   localparam int BUFFER_BYTES = 2048;
   localparam int MAX_SEGS     = 8;

   localparam int LEN_W   = 15;
   localparam int RING_W  = 6;
   localparam int SEG_W   = 12;
   localparam int CMD_W   = 8;
   localparam int SEGS_W  = LEN_W + 1 - $clog2(BUFFER_BYTES);
   localparam int BUF_SHIFT = $clog2(BUFFER_BYTES);

   localparam int REQ_DATA_W  = LEN_W + RING_W;
   localparam int REQ_TDATA_W = ((REQ_DATA_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = 1 + 1 + RING_W + SEG_W + CMD_W + RING_W;
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;

   localparam logic [CMD_W-1:0] CMD_EOP  = CMD_W'(1 << 0);
   localparam logic [CMD_W-1:0] CMD_IFCS = CMD_W'(1 << 1);
   localparam logic [CMD_W-1:0] CMD_RS   = CMD_W'(1 << 3);

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_CHECK,
      STATE_SEG
   } state_type;

   typedef struct packed {
      logic reject;
      logic empty;
   } admit_type;

   typedef struct packed {
      logic [SEG_W-1:0]  num;
      logic [LEN_W-1:0]  rem_next;
      logic [RING_W-1:0] tail_next;
      logic              is_last;
   } seg_type;

endpackage

// ===== hw/rtl/txdr_admit.sv =====
module txdr_admit (
   input  logic [txdr_pkg::LEN_W-1:0]  frame_length,
   input  logic [txdr_pkg::RING_W-1:0] head,
   input  logic [txdr_pkg::RING_W-1:0] tail,
   output txdr_pkg::admit_type         admit
);
   import txdr_pkg::*;

   logic [LEN_W:0]    len_round;
   logic [SEGS_W-1:0] segs;
   logic [RING_W-1:0] used;
   logic [RING_W-1:0] free_slots;

   always_comb begin
      len_round = {1'b0, frame_length} + (LEN_W + 1)'(BUFFER_BYTES - 1);
      segs      = SEGS_W'(len_round >> BUF_SHIFT);
      if (tail >= head) begin
         used = tail - head;
      end else begin
         used = RING_W'((RING_W + 1)'(tail) + (RING_W + 1)'(RING_DEPTH) - (RING_W + 1)'(head));
      end
      free_slots   = RING_W'(RING_DEPTH - 1) - used;
      admit.empty  = (segs == '0);
      admit.reject = (segs > SEGS_W'(MAX_SEGS)) ||
                     ((RING_W + SEGS_W)'(segs) > (RING_W + SEGS_W)'(free_slots));
   end

endmodule

// ===== hw/rtl/txdr_seg_unit.sv =====
module txdr_seg_unit (
   input  logic [txdr_pkg::LEN_W-1:0]  rem,
   input  logic [txdr_pkg::RING_W-1:0] tail,
   output txdr_pkg::seg_type           seg
);
   import txdr_pkg::*;

   always_comb begin
      seg.is_last  = (rem <= LEN_W'(BUFFER_BYTES));
      seg.num      = seg.is_last ? SEG_W'(rem) : SEG_W'(BUFFER_BYTES);
      seg.rem_next = rem - LEN_W'(seg.num);
      if (tail == RING_W'(RING_DEPTH - 1)) begin
         seg.tail_next = '0;
      end else begin
         seg.tail_next = tail + RING_W'(1);
      end
   end

endmodule

// ===== hw/rtl/tx_descriptor_ring_producer_top.sv =====
// Transmit descriptor ring producer. Each request beat carries a frame length and the
// current hardware head index; the block owns the ring tail and answers with one response
// beat per descriptor (slot, segment length, command byte and the advanced tail), or with a
// single non-descriptor beat when the frame is empty, needs more than MAX_SEGS segments or
// the ring lacks free slots. The last response beat of a frame has tlast set. An accepted
// request passes through the admission check state and then, if admitted, the segment state
// before the next request can be taken. The segment unit produces one descriptor per cycle
// while the response output is not stalled.
module tx_descriptor_ring_producer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // frame_length, hw_head
   input  logic [txdr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status, desc_valid, slot, seg_length, command, new_tail
   output logic [txdr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast
);
   import txdr_pkg::*;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [RING_W-1:0] head_ff, head_in;
   logic [RING_W-1:0] tail_ff, tail_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_status_ff, out_status_in;
   logic              out_desc_ff, out_desc_in;
   logic [RING_W-1:0] out_slot_ff, out_slot_in;
   logic [SEG_W-1:0]  out_len_ff, out_len_in;
   logic [CMD_W-1:0]  out_cmd_ff, out_cmd_in;
   logic [RING_W-1:0] out_tail_ff, out_tail_in;
   logic              out_last_ff, out_last_in;

   logic              out_free;
   logic              load_beat;
   admit_type         admit;
   seg_type           seg;

   txdr_admit u_admit (
      .frame_length (rem_ff),
      .head         (head_ff),
      .tail         (tail_ff),
      .admit        (admit)
   );

   txdr_seg_unit u_seg_unit (
      .rem  (rem_ff),
      .tail (tail_ff),
      .seg  (seg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         tail_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      head_ff       <= head_in;
      out_status_ff <= out_status_in;
      out_desc_ff   <= out_desc_in;
      out_slot_ff   <= out_slot_in;
      out_len_ff    <= out_len_in;
      out_cmd_ff    <= out_cmd_in;
      out_tail_ff   <= out_tail_in;
      out_last_ff   <= out_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      out_status_in = out_status_ff;
      out_desc_in   = out_desc_ff;
      out_slot_in   = out_slot_ff;
      out_len_in    = out_len_ff;
      out_cmd_in    = out_cmd_ff;
      out_tail_in   = out_tail_ff;
      out_last_in   = out_last_ff;
      out_free      = !out_valid_ff || rsp_tready;
      load_beat     = 1'b0;
      req_tready    = 1'b0;

      unique case (state_ff)
         STATE_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rem_in   = req_tdata[LEN_W-1:0];
               head_in  = req_tdata[LEN_W +: RING_W];
               state_in = STATE_CHECK;
            end
         end
         STATE_CHECK: begin
            if (admit.reject || admit.empty) begin
               if (out_free) begin
                  load_beat     = 1'b1;
                  out_status_in = admit.reject ? STATUS_REJECT : STATUS_OK;
                  out_desc_in   = 1'b0;
                  out_slot_in   = '0;
                  out_len_in    = '0;
                  out_cmd_in    = '0;
                  out_tail_in   = tail_ff;
                  out_last_in   = 1'b1;
                  state_in      = STATE_IDLE;
               end
            end else begin
               state_in = STATE_SEG;
            end
         end
         STATE_SEG: begin
            if (out_free) begin
               load_beat     = 1'b1;
               out_status_in = STATUS_OK;
               out_desc_in   = 1'b1;
               out_slot_in   = tail_ff;
               out_len_in    = seg.num;
               out_cmd_in    = seg.is_last ? (CMD_RS | CMD_IFCS | CMD_EOP) : CMD_RS;
               out_tail_in   = seg.tail_next;
               out_last_in   = seg.is_last;
               rem_in        = seg.rem_next;
               tail_in       = seg.tail_next;
               if (seg.is_last) begin
                  state_in = STATE_IDLE;
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase

      out_valid_in = load_beat || (out_valid_ff && !rsp_tready);
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_TDATA_W'({out_tail_ff, out_cmd_ff, out_len_ff, out_slot_ff,
                                     out_desc_ff, out_status_ff});

`ifndef ASSERT_OFF
   // The tail moves only when a descriptor beat is loaded.
   assert property (@(posedge clock) disable iff (reset)
      !(load_beat && out_desc_in) |=> $stable(tail_ff))
      else $error("Tail changed without a descriptor beat.");

   // A loaded descriptor reports the tail the block now holds.
   assert property (@(posedge clock) disable iff (reset)
      (load_beat && out_desc_in) |=> (out_tail_ff == tail_ff))
      else $error("Descriptor new_tail does not match the ring tail.");

   // A beat without a descriptor always closes its frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_desc_ff) |-> rsp_tlast)
      else $error("Non-descriptor beat without tlast.");

   // Segmenting never runs with nothing left to send.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_SEG) |-> (rem_ff != '0))
      else $error("Segment state entered with zero remaining length.");
`endif

endmodule
